@@ rtl/core/dce_pkg.sv @@
// Shared constants and widths for the displacement covariance engine.
package dce_pkg;

    localparam int MAX_PARTICLES = 16;
    localparam int MAX_FRAMES    = 256;

    localparam int PART_W  = $clog2(MAX_PARTICLES);
    localparam int FRAME_W = $clog2(MAX_FRAMES);
    localparam int ADDR_W  = PART_W + FRAME_W + 1;
    localparam int DEPTH   = MAX_PARTICLES * MAX_FRAMES * 2;

    localparam int PC_W    = 5;
    localparam int FC_W    = 9;
    localparam int CNT_W   = 13;
    localparam int POS_W   = 32;
    localparam int VAL_W   = 64;

    localparam int ITER_W  = FRAME_W + 1;
    localparam int SUM_W   = POS_W + FRAME_W + 1;
    localparam int DIFF_W  = POS_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int ACC_W   = PROD_W + FRAME_W;
    localparam int DIV_W   = ACC_W;
    localparam int DCNT_W  = $clog2(DIV_W + 1);
    localparam int REM_W   = FC_W;
    localparam int SCL_W   = 2 * POS_W + 1;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_COV  = 2'd1,
        OP_MEAN = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FEW_FRAMES = 2'd1,
        ST_INCOMPLETE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_PARTICLES = 2'd0,
        REG_FRAMES    = 2'd1,
        REG_INV_SCALE = 2'd2
    } reg_index_t;

endpackage

@@ rtl/core/displacement_covariance_engine_unit.sv @@
// Displacement covariance engine: position store, mean and covariance sequencer.
//
// Loads scale each 2D position by inv_scale and write the x and y words into a
// single-port-write, dual-port-read position memory. A mean read walks the
// stored frames once and then runs the shared one-bit-per-cycle divider. A
// covariance read sums both coordinates in one pass, divides twice for the two
// means, walks the frames again through a subtract / multiply / accumulate
// pipeline and divides the sum of products. Items are worked one at a time; the
// next item is taken while a finished result waits on the m_ side. Error reads
// and loads skip the frame walk and the divider. The position memory has no
// reset; a read must only touch slots that were loaded. Configuration is
// written through the APB port; the user must write it only while the block is
// idle, as the block itself does not enforce this.
module displacement_covariance_engine_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_opcode,
    input  logic [3:0]                  s_particle,
    input  logic [7:0]                  s_frame,
    input  logic signed [31:0]          s_x_pos,
    input  logic signed [31:0]          s_y_pos,
    input  logic [4:0]                  s_row,
    input  logic [4:0]                  s_col,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [63:0]          m_value,
    output logic [1:0]                  m_status,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_LWRX, S_LWRY, S_SUM, S_DIVA, S_DIVB, S_PROD, S_DIVV, S_OUT
    } state_t;

    // configuration registers
    logic [dce_pkg::PC_W-1:0]   pcount_reg;
    logic [dce_pkg::FC_W-1:0]   fcount_reg;
    logic [31:0]                inv_scale_reg;
    logic [dce_pkg::CNT_W-1:0]  samples_reg;

    logic cfg_we;
    logic [dce_pkg::PC_W-1:0] pc_clamp;
    logic [dce_pkg::FC_W-1:0] fc_clamp;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb begin
        pc_clamp = pwdata[dce_pkg::PC_W-1:0];
        if (pc_clamp == '0) begin
            pc_clamp = dce_pkg::PC_W'(1);
        end else if (pc_clamp > dce_pkg::PC_W'(dce_pkg::MAX_PARTICLES)) begin
            pc_clamp = dce_pkg::PC_W'(dce_pkg::MAX_PARTICLES);
        end
        fc_clamp = pwdata[dce_pkg::FC_W-1:0];
        if (fc_clamp == '0) begin
            fc_clamp = dce_pkg::FC_W'(1);
        end else if (fc_clamp > dce_pkg::FC_W'(dce_pkg::MAX_FRAMES)) begin
            fc_clamp = dce_pkg::FC_W'(dce_pkg::MAX_FRAMES);
        end
    end

    always_comb begin
        case (paddr[3:2])
            dce_pkg::REG_PARTICLES: prdata = 32'(pcount_reg);
            dce_pkg::REG_FRAMES:    prdata = 32'(fcount_reg);
            dce_pkg::REG_INV_SCALE: prdata = inv_scale_reg;
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcount_reg    <= dce_pkg::PC_W'(dce_pkg::MAX_PARTICLES);
            fcount_reg    <= dce_pkg::FC_W'(dce_pkg::MAX_FRAMES);
            inv_scale_reg <= 32'h0001_0000;
        end else if (cfg_we) begin
            case (paddr[3:2])
                dce_pkg::REG_PARTICLES: pcount_reg    <= pc_clamp;
                dce_pkg::REG_FRAMES:    fcount_reg    <= fc_clamp;
                dce_pkg::REG_INV_SCALE: inv_scale_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // position memory: one write, two registered reads
    logic [dce_pkg::POS_W-1:0]  pos_mem [dce_pkg::DEPTH];
    logic                       mem_we;
    logic [dce_pkg::ADDR_W-1:0] mem_waddr, addr_a, addr_b;
    logic [dce_pkg::POS_W-1:0]  mem_wdata;
    logic [dce_pkg::POS_W-1:0]  rda_reg, rdb_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pos_mem[mem_waddr] <= mem_wdata;
        end
        rda_reg <= pos_mem[addr_a];
        rdb_reg <= pos_mem[addr_b];
    end

    // sequencer state
    state_t state_reg;
    logic                          accept;
    logic [1:0]                    op_reg;
    logic [dce_pkg::PART_W-1:0]    lpart_reg;
    logic [dce_pkg::FRAME_W-1:0]   lframe_reg;
    logic [4:0]                    row_reg, col_reg;
    logic signed [dce_pkg::SCL_W-1:0] px_reg, py_reg;
    logic [dce_pkg::ITER_W-1:0]    iss_reg;
    logic                          v1_reg, v2_reg, v3_reg;
    logic signed [dce_pkg::SUM_W-1:0]  suma_reg, sumb_reg;
    logic signed [dce_pkg::POS_W-1:0]  meana_reg, meanb_reg;
    logic signed [dce_pkg::DIFF_W-1:0] dr_reg, dc_reg;
    logic signed [dce_pkg::PROD_W-1:0] prod_reg;
    logic signed [dce_pkg::ACC_W-1:0]  acc_reg;
    logic [dce_pkg::DIV_W-1:0]     quo_reg;
    logic [dce_pkg::REM_W-1:0]     rem_reg;
    logic [dce_pkg::DCNT_W-1:0]    dcnt_reg;
    logic                          dneg_reg;
    logic signed [63:0]            res_value_reg;
    logic [1:0]                    res_status_reg;
    logic                          m_valid_reg;
    logic signed [63:0]            m_value_reg;
    logic [1:0]                    m_status_reg;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;

    // status checks, valid while idle with stable configuration
    logic [dce_pkg::PC_W+dce_pkg::FC_W-1:0] need_samples;
    logic few_frames, incomplete, row_in, col_in, load_in;
    assign need_samples = (dce_pkg::PC_W+dce_pkg::FC_W)'(pcount_reg) *
                          (dce_pkg::PC_W+dce_pkg::FC_W)'(fcount_reg);
    assign few_frames = fcount_reg < {pcount_reg[dce_pkg::PC_W-2:0], 1'b0} ||
                        pcount_reg[dce_pkg::PC_W-1] &&
                        (fcount_reg < dce_pkg::FC_W'(2*dce_pkg::MAX_PARTICLES));
    assign incomplete = (dce_pkg::PC_W+dce_pkg::FC_W)'(samples_reg) < need_samples;
    assign row_in  = dce_pkg::PC_W'(s_row[4:1]) < pcount_reg;
    assign col_in  = dce_pkg::PC_W'(s_col[4:1]) < pcount_reg;
    assign load_in = dce_pkg::PC_W'(s_particle) < pcount_reg &&
                     dce_pkg::FC_W'(s_frame) < fcount_reg;

    // load scaling: multiply by the Q16.16 inv_scale, floor and saturate to 32 bits
    function automatic logic [dce_pkg::POS_W-1:0] sat_pos(
        input logic signed [dce_pkg::SCL_W-1:0] p);
        logic signed [dce_pkg::SCL_W-1:0] q;
        begin
            q = p >>> 16;
            if (q > dce_pkg::SCL_W'(32'sh7FFF_FFFF)) begin
                sat_pos = 32'h7FFF_FFFF;
            end else if (q < -(dce_pkg::SCL_W'(33'sh0_8000_0000))) begin
                sat_pos = 32'h8000_0000;
            end else begin
                sat_pos = q[dce_pkg::POS_W-1:0];
            end
        end
    endfunction

    function automatic logic signed [dce_pkg::DIFF_W-1:0] DIFF_SEXT(
        input logic [dce_pkg::POS_W-1:0] v);
        begin
            DIFF_SEXT = dce_pkg::DIFF_W'($signed(v));
        end
    endfunction

    // memory addressing
    logic issuing, walk_done, pipe_idle;
    assign issuing   = (state_reg == S_SUM || state_reg == S_PROD) &&
                       (iss_reg < dce_pkg::ITER_W'(fcount_reg));
    assign pipe_idle = !v1_reg && !v2_reg && !v3_reg;
    assign walk_done = !issuing && pipe_idle;
    assign addr_a = {row_reg[4:1], iss_reg[dce_pkg::FRAME_W-1:0], row_reg[0]};
    assign addr_b = {col_reg[4:1], iss_reg[dce_pkg::FRAME_W-1:0], col_reg[0]};
    assign mem_we    = (state_reg == S_LWRX) || (state_reg == S_LWRY);
    assign mem_waddr = {lpart_reg, lframe_reg, state_reg == S_LWRY};
    assign mem_wdata = (state_reg == S_LWRY) ? sat_pos(py_reg) : sat_pos(px_reg);

    // divider step: restoring, one quotient bit per cycle
    logic [dce_pkg::REM_W:0]     rem_sh;
    logic                        q_bit;
    logic [dce_pkg::REM_W-1:0]   rem_step;
    logic [dce_pkg::DIV_W-1:0]   quo_step;
    assign rem_sh   = {rem_reg, quo_reg[dce_pkg::DIV_W-1]};
    assign q_bit    = rem_sh >= (dce_pkg::REM_W+1)'(fcount_reg);
    assign rem_step = q_bit ? dce_pkg::REM_W'(rem_sh - (dce_pkg::REM_W+1)'(fcount_reg))
                            : rem_sh[dce_pkg::REM_W-1:0];
    assign quo_step = {quo_reg[dce_pkg::DIV_W-2:0], q_bit};

    logic signed [dce_pkg::POS_W-1:0] mean_step;
    assign mean_step = dneg_reg ? -quo_step[dce_pkg::POS_W-1:0]
                                : quo_step[dce_pkg::POS_W-1:0];

    logic signed [63:0] cov_sat;
    always_comb begin
        if (!dneg_reg) begin
            cov_sat = (quo_step > dce_pkg::DIV_W'(64'h7FFF_FFFF_FFFF_FFFF))
                      ? 64'sh7FFF_FFFF_FFFF_FFFF : quo_step[63:0];
        end else begin
            cov_sat = (quo_step >= dce_pkg::DIV_W'(64'h8000_0000_0000_0000))
                      ? 64'sh8000_0000_0000_0000 : -quo_step[63:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            samples_reg <= '0;
            m_valid_reg <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
        end else begin
            // hold the result until taken
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // walk pipeline: memory data, displacements, product
            v1_reg   <= issuing;
            v2_reg   <= v1_reg && (state_reg == S_PROD);
            v3_reg   <= v2_reg;
            dr_reg   <= DIFF_SEXT(rda_reg) - DIFF_SEXT(meana_reg);
            dc_reg   <= DIFF_SEXT(rdb_reg) - DIFF_SEXT(meanb_reg);
            prod_reg <= dr_reg * dc_reg;
            if (issuing) begin
                iss_reg <= iss_reg + 1'b1;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        op_reg     <= s_opcode;
                        lpart_reg  <= s_particle;
                        lframe_reg <= s_frame;
                        row_reg    <= s_row;
                        col_reg    <= s_col;
                        px_reg     <= dce_pkg::SCL_W'(s_x_pos) *
                                      $signed({1'b0, inv_scale_reg});
                        py_reg     <= dce_pkg::SCL_W'(s_y_pos) *
                                      $signed({1'b0, inv_scale_reg});
                        iss_reg    <= '0;
                        suma_reg   <= '0;
                        sumb_reg   <= '0;
                        res_value_reg  <= '0;
                        res_status_reg <= dce_pkg::ST_OK;
                        state_reg      <= S_OUT;
                        if (s_opcode == dce_pkg::OP_LOAD) begin
                            if (load_in) begin
                                state_reg <= S_LWRX;
                            end
                        end else if (s_opcode == dce_pkg::OP_COV ||
                                     s_opcode == dce_pkg::OP_MEAN) begin
                            if (few_frames) begin
                                res_status_reg <= dce_pkg::ST_FEW_FRAMES;
                            end else if (incomplete) begin
                                res_status_reg <= dce_pkg::ST_INCOMPLETE;
                            end else if (row_in && (col_in ||
                                         s_opcode == dce_pkg::OP_MEAN)) begin
                                state_reg <= S_SUM;
                            end
                        end
                    end
                end
                S_LWRX: state_reg <= S_LWRY;
                S_LWRY: begin
                    if (samples_reg != dce_pkg::COUNT_MAX) begin
                        samples_reg <= samples_reg + 1'b1;
                    end
                    state_reg <= S_OUT;
                end
                S_SUM: begin
                    if (v1_reg) begin
                        suma_reg <= suma_reg + dce_pkg::SUM_W'($signed(rda_reg));
                        sumb_reg <= sumb_reg + dce_pkg::SUM_W'($signed(rdb_reg));
                    end
                    if (walk_done) begin
                        dneg_reg  <= suma_reg[dce_pkg::SUM_W-1];
                        quo_reg   <= dce_pkg::DIV_W'(suma_reg[dce_pkg::SUM_W-1]
                                     ? -suma_reg : suma_reg);
                        rem_reg   <= '0;
                        dcnt_reg  <= dce_pkg::DCNT_W'(dce_pkg::DIV_W);
                        state_reg <= S_DIVA;
                    end
                end
                S_DIVA, S_DIVB, S_DIVV: begin
                    quo_reg  <= quo_step;
                    rem_reg  <= rem_step;
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == dce_pkg::DCNT_W'(1)) begin
                        rem_reg  <= '0;
                        dcnt_reg <= dce_pkg::DCNT_W'(dce_pkg::DIV_W);
                        if (state_reg == S_DIVA) begin
                            meana_reg <= mean_step;
                            if (op_reg == dce_pkg::OP_MEAN) begin
                                res_value_reg <= 64'(mean_step);
                                state_reg     <= S_OUT;
                            end else begin
                                dneg_reg  <= sumb_reg[dce_pkg::SUM_W-1];
                                quo_reg   <= dce_pkg::DIV_W'(sumb_reg[dce_pkg::SUM_W-1]
                                             ? -sumb_reg : sumb_reg);
                                state_reg <= S_DIVB;
                            end
                        end else if (state_reg == S_DIVB) begin
                            meanb_reg <= mean_step;
                            iss_reg   <= '0;
                            acc_reg   <= '0;
                            state_reg <= S_PROD;
                        end else begin
                            res_value_reg <= cov_sat;
                            state_reg     <= S_OUT;
                        end
                    end
                end
                S_PROD: begin
                    if (v3_reg) begin
                        acc_reg <= acc_reg + dce_pkg::ACC_W'(prod_reg);
                    end
                    if (walk_done) begin
                        dneg_reg  <= acc_reg[dce_pkg::ACC_W-1];
                        quo_reg   <= dce_pkg::DIV_W'(acc_reg[dce_pkg::ACC_W-1]
                                     ? -acc_reg : acc_reg);
                        state_reg <= S_DIVV;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_value_reg  <= res_value_reg;
                        m_status_reg <= res_status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // the divider never runs with an empty step count
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIVA || state_reg == S_DIVB || state_reg == S_DIVV)
        |-> dcnt_reg != '0)
        else $error("divider step count ran out");

    // the sample count never decreases between resets
    a_count_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> samples_reg >= $past(samples_reg))
        else $error("sample count went backward");

    // each frame-walk read sets the read-data valid flag
    a_walk_read: assert property (@(posedge aclk) disable iff (!aresetn)
        issuing |=> v1_reg && (state_reg == S_SUM || state_reg == S_PROD ||
                               state_reg == S_DIVA || state_reg == S_DIVV))
        else $error("walk read lost");

    // an accepted beat always leaves the idle state
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("accepted beat left block idle");

endmodule
